// ===== hw/rtl/ala_pkg.sv =====
// ============================================================================
// Level assist package
// Shared widths, codes, defaults and record types for the level assistant.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ala_pkg;

    // Sample and datapath widths
    localparam int SAMPLE_BITS = 14;
    localparam int AXES        = 3;
    localparam int AXIS_X      = 0;
    localparam int AXIS_Y      = 1;
    localparam int AXIS_Z      = 2;
    localparam int STEP_W      = SAMPLE_BITS + 1;
    localparam int SQUARE_W    = 2 * SAMPLE_BITS - 1;
    localparam int GRAV_SUM_W  = 2 * SAMPLE_BITS;
    localparam int LIMIT_W     = 14;
    localparam int GRAV_SQ_W   = 2 * LIMIT_W;
    localparam int UPRIGHT_W   = 13;
    localparam int TILT_LIM_W  = 10;
    localparam int ERR_W       = 4;
    localparam int RUN_W       = 4;
    localparam int TILT_W      = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;

    // Tilt division: |lateral| * 1000 over the vertical magnitude
    localparam int PERMILLE     = 1000;
    localparam int DIVIDEND_W   = 24;
    localparam int DIVISOR_W    = SAMPLE_BITS;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int TILT_MAG_POS = 2 ** (TILT_W - 1) - 1;
    localparam int TILT_MAG_NEG = 2 ** (TILT_W - 1);

    localparam logic signed [TILT_W-1:0] TILT_MAX = TILT_W'(TILT_MAG_POS);
    localparam logic signed [TILT_W-1:0] TILT_MIN = TILT_W'(TILT_MAG_NEG);
    localparam logic [RUN_W-1:0]         FAILURE_MAX = 4'd15;

    // Register defaults after reset
    localparam logic                  DEF_PRESENT     = 1'b1;
    localparam logic [LIMIT_W-1:0]    DEF_FSTEP_LIM   = 14'd25;
    localparam logic [LIMIT_W-1:0]    DEF_RSTEP_LIM   = 14'd80;
    localparam logic [UPRIGHT_W-1:0]  DEF_UPRIGHT_MIN = 13'd600;
    localparam logic [LIMIT_W-1:0]    DEF_GRAV_MIN    = 14'd700;
    localparam logic [LIMIT_W-1:0]    DEF_GRAV_MAX    = 14'd1400;
    localparam logic [TILT_LIM_W-1:0] DEF_TILT_LIM    = 10'd70;
    localparam logic [ERR_W-1:0]      DEF_ERR_LIM     = 4'd3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_FAIL   = 2'd1,
        CMD_CAL    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        LS_UNAVAIL = 2'd0,
        LS_HOLD    = 2'd1,
        LS_ADJUST  = 2'd2,
        LS_READY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CAL_OK         = 2'd0,
        CAL_NOT_READY  = 2'd1,
        CAL_NOT_STEADY = 2'd2
    } t_cal;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT     = 3'd0,
        CFG_FSTEP_LIM   = 3'd1,
        CFG_RSTEP_LIM   = 3'd2,
        CFG_UPRIGHT_MIN = 3'd3,
        CFG_GRAV_MIN    = 3'd4,
        CFG_GRAV_MAX    = 3'd5,
        CFG_TILT_LIM    = 3'd6,
        CFG_ERR_LIM     = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_CAL_MERGE,
        S_CHECK,
        S_CAL,
        S_DIV,
        S_DONE
    } t_state;

    // What one axis lane found for the item
    typedef struct packed {
        logic [STEP_W-1:0]   filt_step;
        logic [STEP_W-1:0]   raw_step;
        logic [SQUARE_W-1:0] square;
    } t_lane_out;

    // Limits the merging stage compares against
    typedef struct packed {
        logic [LIMIT_W-1:0]   fstep;
        logic [LIMIT_W-1:0]   rstep;
        logic [UPRIGHT_W-1:0] upright;
        logic [LIMIT_W-1:0]   grav_min;
        logic [LIMIT_W-1:0]   grav_max;
    } t_limits;

    // Combined findings of the three lanes
    typedef struct packed {
        logic                     steady_ok;
        logic                     gravity_ok;
        logic                     vert_ge_min;
        logic                     vert_zero;
        logic                     lat_axis;
        logic [DIVISOR_W-1:0]     vert;
        logic signed [STEP_W-1:0] lat;
    } t_merge;

    typedef struct packed {
        t_status                  status;
        logic signed [TILT_W-1:0] tilt;
        t_cal                     cal;
    } t_result;

    // Magnitude of a sample; the most negative value maps onto its unsigned size.
    function automatic logic [SAMPLE_BITS-1:0] mag_sample(input t_sample v);
        logic [SAMPLE_BITS-1:0] m;
        m = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ala_intf.sv =====
// ============================================================================
// Level assist channels
// Valid/ready channels for input items, result items and register writes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ala_item_if import ala_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [SAMPLE_BITS-1:0] accel_x;
    logic [SAMPLE_BITS-1:0] accel_y;
    logic [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, command, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, command, accel_x, accel_y, accel_z, output ready);
endinterface

interface ala_result_if import ala_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        level_status;
    logic [TILT_W-1:0] tilt_permille;
    logic              capture_allowed;
    logic [1:0]        calibrate_result;

    modport source (output valid, level_status, tilt_permille, capture_allowed,
                    calibrate_result, input ready);
    modport sink   (input valid, level_status, tilt_permille, capture_allowed,
                    calibrate_result, output ready);
endinterface

interface ala_cfg_if import ala_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/accel_level_assist_core.sv =====
// ============================================================================
// Accelerometer level assistant
// Filters 3-axis samples in three axis lanes, merges their findings, checks
// steadiness, uprightness and gravity, and reports tilt and level status.
// ============================================================================
// Flow: a filtered sample passes the axis lanes, the merging stage and the
// check state and, when it qualifies, the 24-step tilt divider; other items
// skip the divider. One item at a time: a new item is taken once the previous
// result has moved to the output register.
// Reset: synchronous, active low; registers return to defaults, the filter
// is unprimed and all run counters clear. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module accel_level_assist_core import ala_pkg::*; #(
    parameter int FILTER_SHIFT = 2,
    parameter int STEADY_COUNT = 4,
    parameter int LEVEL_COUNT  = 3
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ala_cfg_if.sink       i_cfg,
    ala_item_if.sink      i_item,
    ala_result_if.source  o_result
);

    // Configuration registers
    logic                  r_present;
    logic [LIMIT_W-1:0]    r_fstep_lim;
    logic [LIMIT_W-1:0]    r_rstep_lim;
    logic [UPRIGHT_W-1:0]  r_upright_min;
    logic [LIMIT_W-1:0]    r_grav_min;
    logic [LIMIT_W-1:0]    r_grav_max;
    logic [TILT_LIM_W-1:0] r_tilt_lim;
    logic [ERR_W-1:0]      r_err_lim;

    // Control state
    t_state            r_state, n_state;
    logic [RUN_W-1:0]  r_steady, n_steady;
    logic [RUN_W-1:0]  r_level, n_level;
    logic [RUN_W-1:0]  r_fail, n_fail;
    logic              r_primed, n_primed;
    t_sample           r_zero_x, n_zero_x;
    t_sample           r_zero_y, n_zero_y;
    logic              r_tilt_neg, n_tilt_neg;
    t_result           r_res, n_res;
    logic              r_out_valid;
    t_result           r_out;

    logic                    w_item_acc;
    logic                    w_out_free;
    logic                    w_lane_load;
    logic                    w_lane_update;
    logic                    w_merge_en;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [DIVIDEND_W-1:0]   w_quotient;
    logic [DIVIDEND_W-1:0]   w_dividend;
    logic [STEP_W-1:0]       w_lat_mag;
    logic [RUN_W-1:0]        w_steady_inc;
    logic [RUN_W-1:0]        w_level_inc;
    logic signed [DIVIDEND_W:0] w_neg_q;
    logic signed [TILT_W-1:0]   w_tilt;
    t_sample                 w_raw  [AXES];
    t_sample                 w_filt [AXES];
    t_lane_out               w_lane [AXES];
    t_limits                 w_limits;
    t_merge                  w_merge;

    assign w_item_acc = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_merge_en = (r_state == S_MERGE) || (r_state == S_CAL_MERGE);

    assign w_raw[AXIS_X] = t_sample'(i_item.accel_x);
    assign w_raw[AXIS_Y] = t_sample'(i_item.accel_y);
    assign w_raw[AXIS_Z] = t_sample'(i_item.accel_z);

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present     <= DEF_PRESENT;
            r_fstep_lim   <= DEF_FSTEP_LIM;
            r_rstep_lim   <= DEF_RSTEP_LIM;
            r_upright_min <= DEF_UPRIGHT_MIN;
            r_grav_min    <= DEF_GRAV_MIN;
            r_grav_max    <= DEF_GRAV_MAX;
            r_tilt_lim    <= DEF_TILT_LIM;
            r_err_lim     <= DEF_ERR_LIM;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PRESENT:     r_present     <= i_cfg.data[0];
                CFG_FSTEP_LIM:   r_fstep_lim   <= i_cfg.data[LIMIT_W-1:0];
                CFG_RSTEP_LIM:   r_rstep_lim   <= i_cfg.data[LIMIT_W-1:0];
                CFG_UPRIGHT_MIN: r_upright_min <= i_cfg.data[UPRIGHT_W-1:0];
                CFG_GRAV_MIN:    r_grav_min    <= i_cfg.data[LIMIT_W-1:0];
                CFG_GRAV_MAX:    r_grav_max    <= i_cfg.data[LIMIT_W-1:0];
                CFG_TILT_LIM:    r_tilt_lim    <= i_cfg.data[TILT_LIM_W-1:0];
                CFG_ERR_LIM:     r_err_lim     <= i_cfg.data[ERR_W-1:0];
                default:         r_present     <= r_present;
            endcase
        end
    end

    // Axis lanes
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        ala_axis_lane #(
            .FILTER_SHIFT (FILTER_SHIFT)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_lane_load),
            .i_update   (w_lane_update),
            .i_raw      (w_raw[g]),
            .o_filtered (w_filt[g]),
            .o_lane     (w_lane[g])
        );
    end

    // Merging stage
    always_comb begin
        w_limits.fstep    = r_fstep_lim;
        w_limits.rstep    = r_rstep_lim;
        w_limits.upright  = r_upright_min;
        w_limits.grav_min = r_grav_min;
        w_limits.grav_max = r_grav_max;
    end

    ala_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_merge_en),
        .i_lane   (w_lane),
        .i_filt_x (w_filt[AXIS_X]),
        .i_filt_y (w_filt[AXIS_Y]),
        .i_zero_x (r_zero_x),
        .i_zero_y (r_zero_y),
        .i_limits (w_limits),
        .o_merge  (w_merge)
    );

    // Tilt division on magnitudes; the sign is applied afterwards.
    always_comb begin
        w_lat_mag  = w_merge.lat[STEP_W-1] ? STEP_W'(-w_merge.lat) : STEP_W'(w_merge.lat);
        w_dividend = DIVIDEND_W'(w_lat_mag) * DIVIDEND_W'(PERMILLE);
    end

    ala_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_merge.vert),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Signed, saturated tilt from the quotient
    always_comb begin
        w_neg_q = -$signed({1'b0, w_quotient});
        if (r_tilt_neg) begin
            w_tilt = (w_quotient > DIVIDEND_W'(TILT_MAG_NEG)) ? TILT_MIN
                                                              : w_neg_q[TILT_W-1:0];
        end else begin
            w_tilt = (w_quotient > DIVIDEND_W'(TILT_MAG_POS)) ? TILT_MAX
                                                              : w_quotient[TILT_W-1:0];
        end
    end

    assign w_steady_inc = (r_steady < RUN_W'(STEADY_COUNT)) ? r_steady + 1'b1 : r_steady;
    assign w_level_inc  = (r_level < RUN_W'(LEVEL_COUNT)) ? r_level + 1'b1 : r_level;

    // Sequencer: next state and per-item bookkeeping
    always_comb begin
        n_state       = r_state;
        n_steady      = r_steady;
        n_level       = r_level;
        n_fail        = r_fail;
        n_primed      = r_primed;
        n_zero_x      = r_zero_x;
        n_zero_y      = r_zero_y;
        n_tilt_neg    = r_tilt_neg;
        n_res         = r_res;
        w_lane_load   = 1'b0;
        w_lane_update = 1'b0;
        w_div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_item_acc) begin
                    n_res   = '{status: LS_HOLD, tilt: '0, cal: CAL_OK};
                    n_state = S_DONE;
                    unique case (i_item.command)
                        CMD_CAL: begin
                            if (!r_present || !r_primed) begin
                                n_res.cal = CAL_NOT_READY;
                            end else begin
                                n_state = S_CAL_MERGE;
                            end
                        end
                        CMD_FAIL: begin
                            if (!r_present) begin
                                n_res.status = LS_UNAVAIL;
                            end else begin
                                n_fail   = (r_fail < FAILURE_MAX) ? r_fail + 1'b1 : r_fail;
                                n_primed = 1'b0;
                                n_steady = '0;
                                n_level  = '0;
                                if (n_fail >= r_err_lim) begin
                                    n_res.status = LS_UNAVAIL;
                                end
                            end
                        end
                        CMD_SAMPLE: begin
                            if (!r_present) begin
                                n_res.status = LS_UNAVAIL;
                            end else begin
                                n_fail = '0;
                                if (!r_primed) begin
                                    // Priming sample loads the filter.
                                    w_lane_load = 1'b1;
                                    n_primed    = 1'b1;
                                    n_steady    = '0;
                                end else begin
                                    w_lane_update = 1'b1;
                                    n_state       = S_MERGE;
                                end
                            end
                        end
                        default: begin
                            n_res = '{status: LS_HOLD, tilt: '0, cal: CAL_OK};
                        end
                    endcase
                end
            end
            S_MERGE: begin
                n_state = S_CHECK;
            end
            S_CAL_MERGE: begin
                n_state = S_CAL;
            end
            S_CHECK: begin
                n_steady = w_merge.steady_ok ? w_steady_inc : '0;
                if (n_steady < RUN_W'(STEADY_COUNT) || !w_merge.vert_ge_min
                        || w_merge.vert_zero || !w_merge.gravity_ok) begin
                    n_level = '0;
                    n_res   = '{status: LS_HOLD, tilt: '0, cal: CAL_OK};
                    n_state = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_tilt_neg  = w_merge.lat[STEP_W-1];
                    n_state     = S_DIV;
                end
            end
            S_CAL: begin
                n_res   = '{status: LS_HOLD, tilt: '0, cal: CAL_OK};
                n_state = S_DONE;
                if (r_steady < RUN_W'(STEADY_COUNT) || !w_merge.vert_ge_min) begin
                    n_res.cal = CAL_NOT_STEADY;
                end else begin
                    // Lateral axis takes its filtered value as the new zero.
                    n_level = '0;
                    if (w_merge.lat_axis) begin
                        n_zero_y = w_filt[AXIS_Y];
                    end else begin
                        n_zero_x = w_filt[AXIS_X];
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                    n_res   = '{status: LS_HOLD, tilt: w_tilt, cal: CAL_OK};
                    if (w_quotient > DIVIDEND_W'(r_tilt_lim)) begin
                        n_level      = '0;
                        n_res.status = LS_ADJUST;
                    end else begin
                        n_level = w_level_inc;
                        if (w_level_inc >= RUN_W'(LEVEL_COUNT)) begin
                            n_res.status = LS_READY;
                        end
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_steady <= '0;
            r_level  <= '0;
            r_fail   <= '0;
            r_primed <= 1'b0;
            r_zero_x <= '0;
            r_zero_y <= '0;
        end else begin
            r_state  <= n_state;
            r_steady <= n_steady;
            r_level  <= n_level;
            r_fail   <= n_fail;
            r_primed <= n_primed;
            r_zero_x <= n_zero_x;
            r_zero_y <= n_zero_y;
        end
    end

    // Result held for the output register
    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_tilt_neg <= n_tilt_neg;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign i_item.ready              = (r_state == S_IDLE);
    assign o_result.valid            = r_out_valid;
    assign o_result.level_status     = r_out.status;
    assign o_result.tilt_permille    = r_out.tilt;
    assign o_result.capture_allowed  = (r_out.status == LS_READY)
                                    || (r_out.status == LS_UNAVAIL);
    assign o_result.calibrate_result = r_out.cal;

    // The divider is started only on the way into the division state.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == S_DIV))
        else $error("divider started outside the tilt path");

    // Only an accepted read failure unprimes the filter.
    a_unprime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_primed) |-> $past(w_item_acc && i_item.command == CMD_FAIL))
        else $error("filter unprimed without a read failure");

    // Run counters saturate at their targets.
    a_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steady <= RUN_W'(STEADY_COUNT)) && (r_level <= RUN_W'(LEVEL_COUNT)))
        else $error("run counter beyond its target");

endmodule

`default_nettype wire

// ===== hw/rtl/ala_axis_lane.sv =====
// ============================================================================
// Level assist axis lane
// Holds one axis's filter and last raw value, and reports the filtered and
// raw steps and the square of the new filtered value.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ala_axis_lane import ala_pkg::*; #(
    parameter int FILTER_SHIFT = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire logic      i_update,
    input  wire t_sample   i_raw,
    output t_sample        o_filtered,
    output t_lane_out      o_lane
);

    t_sample   r_filtered;
    t_sample   r_last;
    t_lane_out r_lane;

    logic signed [STEP_W-1:0]     w_diff;
    logic signed [STEP_W-1:0]     w_delta;
    logic signed [STEP_W-1:0]     w_sum;
    t_sample                      w_new;
    logic signed [STEP_W-1:0]     w_raw_diff;
    logic signed [2*SAMPLE_BITS-1:0] w_prod;

    // Filter update: the arithmetic shift rounds the step toward minus infinity.
    always_comb begin
        w_diff     = STEP_W'(i_raw) - STEP_W'(r_filtered);
        w_delta    = w_diff >>> FILTER_SHIFT;
        w_sum      = STEP_W'(r_filtered) + w_delta;
        w_new      = w_sum[SAMPLE_BITS-1:0];
        w_raw_diff = STEP_W'(i_raw) - STEP_W'(r_last);
        w_prod     = w_new * w_new;
    end

    // Filter and last raw value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filtered <= '0;
            r_last     <= '0;
        end else if (i_load) begin
            r_filtered <= i_raw;
            r_last     <= i_raw;
        end else if (i_update) begin
            r_filtered <= w_new;
            r_last     <= i_raw;
        end
    end

    // Step magnitudes and square for the merging stage
    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_lane.filt_step <= w_delta[STEP_W-1] ? STEP_W'(-w_delta) : STEP_W'(w_delta);
            r_lane.raw_step  <= w_raw_diff[STEP_W-1] ? STEP_W'(-w_raw_diff)
                                                     : STEP_W'(w_raw_diff);
            r_lane.square    <= w_prod[SQUARE_W-1:0];
        end
    end

    assign o_filtered = r_filtered;
    assign o_lane     = r_lane;

endmodule

`default_nettype wire

// ===== hw/rtl/ala_merge.sv =====
// ============================================================================
// Level assist merging stage
// Combines the lane findings: largest steps, gravity magnitude, dominant
// in-plane axis, vertical magnitude and lateral offset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ala_merge import ala_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_lane_out i_lane [AXES],
    input  wire t_sample   i_filt_x,
    input  wire t_sample   i_filt_y,
    input  wire t_sample   i_zero_x,
    input  wire t_sample   i_zero_y,
    input  wire t_limits   i_limits,
    output t_merge         o_merge
);

    logic [GRAV_SQ_W-1:0]  r_gmin_sq;
    logic [GRAV_SQ_W-1:0]  r_gmax_sq;
    t_merge                r_merge;

    logic [STEP_W-1:0]      w_fmax;
    logic [STEP_W-1:0]      w_rmax;
    logic [GRAV_SUM_W-1:0]  w_gsum;
    logic [SAMPLE_BITS-1:0] w_ax;
    logic [SAMPLE_BITS-1:0] w_ay;
    logic                   w_y_dom;
    t_merge                 w_merge;

    // Gravity bounds squared; they change only with the registers.
    always_ff @(posedge i_clk) begin
        r_gmin_sq <= i_limits.grav_min * i_limits.grav_min;
        r_gmax_sq <= i_limits.grav_max * i_limits.grav_max;
    end

    // Largest steps over the three lanes
    always_comb begin
        w_fmax = i_lane[AXIS_X].filt_step;
        w_rmax = i_lane[AXIS_X].raw_step;
        for (int i = 1; i < AXES; i++) begin
            if (i_lane[i].filt_step > w_fmax) begin
                w_fmax = i_lane[i].filt_step;
            end
            if (i_lane[i].raw_step > w_rmax) begin
                w_rmax = i_lane[i].raw_step;
            end
        end
    end

    // Gravity, dominant axis and lateral offset; Y wins a tie.
    always_comb begin
        w_gsum  = GRAV_SUM_W'(i_lane[AXIS_X].square) + GRAV_SUM_W'(i_lane[AXIS_Y].square)
                + GRAV_SUM_W'(i_lane[AXIS_Z].square);
        w_ax    = mag_sample(i_filt_x);
        w_ay    = mag_sample(i_filt_y);
        w_y_dom = (w_ay >= w_ax);

        w_merge.steady_ok   = (w_fmax <= STEP_W'(i_limits.fstep))
                           && (w_rmax <= STEP_W'(i_limits.rstep));
        w_merge.gravity_ok  = (GRAV_SQ_W'(w_gsum) >= r_gmin_sq)
                           && (GRAV_SQ_W'(w_gsum) <= r_gmax_sq);
        w_merge.vert        = w_y_dom ? w_ay : w_ax;
        w_merge.vert_ge_min = (w_merge.vert >= DIVISOR_W'(i_limits.upright));
        w_merge.vert_zero   = (w_merge.vert == '0);
        w_merge.lat_axis    = !w_y_dom;
        w_merge.lat         = w_y_dom ? STEP_W'(i_filt_x) - STEP_W'(i_zero_x)
                                      : STEP_W'(i_filt_y) - STEP_W'(i_zero_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_merge <= w_merge;
        end
    end

    assign o_merge = r_merge;

endmodule

`default_nettype wire

// ===== hw/rtl/ala_divider.sv =====
// ============================================================================
// Level assist divider
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ala_divider import ala_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [DIVIDEND_W-1:0]  i_dividend,
    input  wire logic [DIVISOR_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [DIVIDEND_W-1:0]       o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fit;
    logic [DIVISOR_W:0]    w_diff;

    // One trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_fit   = (w_trial >= {1'b0, r_divisor});
        w_diff  = w_trial - {1'b0, r_divisor};
    end

    // Control: step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== sim/accel_level_assist_core_tb.sv =====
// ============================================================================
// Level assist core testbench
// Drives samples, read failures and calibrate requests into the level
// assistant through phases of register settings. The expected level status,
// tilt, capture flag and calibrate outcome are tracked by a behavioral model
// of the filter and level logic or given by a directed row, and every result item is checked.
// ============================================================================
`timescale 1ns / 1ps

module accel_level_assist_core_tb;
    import ala_pkg::*;

    localparam int FILTER_SHIFT  = 2;
    localparam int STEADY_COUNT  = 4;
    localparam int LEVEL_COUNT   = 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_START    = 2500;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LINES  = 40;
    localparam int DIRECTED_N    = 25;

    // The command code the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result item as the level logic should produce it.
    typedef struct packed {
        t_status                  status;
        logic signed [TILT_W-1:0] tilt;
        logic                     capture;
        t_cal                     cal;
    } t_level_out;

    // One row of the directed stimulus; the typed result counts when typed is set.
    typedef struct packed {
        logic [1:0]               cmd;
        t_sample                  ax;
        t_sample                  ay;
        t_sample                  az;
        logic                     typed;
        t_status                  status;
        logic signed [TILT_W-1:0] tilt;
        t_cal                     cal;
    } t_drive_row;

    // A full set of register values.
    typedef struct packed {
        logic                  present;
        logic [LIMIT_W-1:0]    fstep;
        logic [LIMIT_W-1:0]    rstep;
        logic [UPRIGHT_W-1:0]  upright;
        logic [LIMIT_W-1:0]    grav_min;
        logic [LIMIT_W-1:0]    grav_max;
        logic [TILT_LIM_W-1:0] tilt_lim;
        logic [ERR_W-1:0]      err_lim;
    } t_setting;

    logic i_clk;
    logic i_rst_n;

    ala_cfg_if    cfg_ch ();
    ala_item_if   sample_ch ();
    ala_result_if level_ch ();

    accel_level_assist_core #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .STEADY_COUNT (STEADY_COUNT),
        .LEVEL_COUNT  (LEVEL_COUNT)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (sample_ch),
        .o_result (level_ch)
    );

    // Register copy of the level model.
    logic                  set_present;
    logic [LIMIT_W-1:0]    set_fstep;
    logic [LIMIT_W-1:0]    set_rstep;
    logic [UPRIGHT_W-1:0]  set_upright;
    logic [LIMIT_W-1:0]    set_grav_min;
    logic [LIMIT_W-1:0]    set_grav_max;
    logic [TILT_LIM_W-1:0] set_tilt_lim;
    logic [ERR_W-1:0]      set_err_lim;

    // Filter and run state of the level model.
    t_sample           lvl_filt     [AXES];
    t_sample           lvl_last_raw [AXES];
    t_sample           lvl_zero     [2];
    logic [RUN_W-1:0]  lvl_steady_run;
    logic [RUN_W-1:0]  lvl_level_run;
    logic [RUN_W-1:0]  lvl_fail_run;
    logic              lvl_primed;

    t_level_out awaited_levels [$];
    t_drive_row directed_rows [DIRECTED_N];

    int items_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    bit calm_src       = 1'b0;
    bit calm_sink      = 1'b0;
    bit sink_hold      = 1'b0;

    // ------------------------------------------------------------------------
    // Level model
    // ------------------------------------------------------------------------

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Builds a result item; the reported tilt saturates to its 17-bit range.
    function automatic t_level_out pack_level(input t_status st, input longint tilt,
                                              input t_cal cal);
        t_level_out r;
        if (tilt > longint'(TILT_MAX))
            tilt = longint'(TILT_MAX);
        if (tilt < longint'(TILT_MIN))
            tilt = longint'(TILT_MIN);
        r.status  = st;
        r.tilt    = tilt[TILT_W-1:0];
        r.capture = (st == LS_READY) || (st == LS_UNAVAIL);
        r.cal     = cal;
        return r;
    endfunction

    function automatic void level_model_reset();
        set_present    = DEF_PRESENT;
        set_fstep      = DEF_FSTEP_LIM;
        set_rstep      = DEF_RSTEP_LIM;
        set_upright    = DEF_UPRIGHT_MIN;
        set_grav_min   = DEF_GRAV_MIN;
        set_grav_max   = DEF_GRAV_MAX;
        set_tilt_lim   = DEF_TILT_LIM;
        set_err_lim    = DEF_ERR_LIM;
        for (int i = 0; i < AXES; i++) begin
            lvl_filt[i]     = '0;
            lvl_last_raw[i] = '0;
        end
        lvl_zero[AXIS_X] = '0;
        lvl_zero[AXIS_Y] = '0;
        lvl_steady_run   = '0;
        lvl_level_run    = '0;
        lvl_fail_run     = '0;
        lvl_primed       = 1'b0;
    endfunction

    // Advances the level model by one accepted item and returns its result.
    function automatic t_level_out level_outcome(input logic [1:0] cmd, input t_sample sx,
                                                 input t_sample sy, input t_sample sz);
        longint raw [AXES];
        longint old_f, step, f_big, r_big;
        longint fx, fy, fz, ax, ay, vert, lat, grav_sq, tilt;
        int     cal_axis;
        f_big = 0;
        r_big = 0;

        // Calibrate: store the lateral zero when primed, steady and upright.
        if (cmd == CMD_CAL) begin
            if (!set_present || !lvl_primed)
                return pack_level(LS_HOLD, 0, CAL_NOT_READY);
            ax = magnitude(longint'(lvl_filt[AXIS_X]));
            ay = magnitude(longint'(lvl_filt[AXIS_Y]));
            if (lvl_steady_run < STEADY_COUNT || ((ax > ay) ? ax : ay) < longint'(set_upright))
                return pack_level(LS_HOLD, 0, CAL_NOT_STEADY);
            cal_axis = (ay >= ax) ? AXIS_X : AXIS_Y;
            lvl_zero[cal_axis] = lvl_filt[cal_axis];
            lvl_level_run = '0;
            return pack_level(LS_HOLD, 0, CAL_OK);
        end
        if (cmd == CMD_UNUSED)
            return pack_level(LS_HOLD, 0, CAL_OK);
        if (!set_present)
            return pack_level(LS_UNAVAIL, 0, CAL_OK);

        // Read failure: count up and drop priming and both runs.
        if (cmd == CMD_FAIL) begin
            if (lvl_fail_run < FAILURE_MAX)
                lvl_fail_run++;
            lvl_primed     = 1'b0;
            lvl_steady_run = '0;
            lvl_level_run  = '0;
            return pack_level((lvl_fail_run >= set_err_lim) ? LS_UNAVAIL : LS_HOLD, 0, CAL_OK);
        end

        lvl_fail_run = '0;
        raw[AXIS_X] = sx;
        raw[AXIS_Y] = sy;
        raw[AXIS_Z] = sz;

        // The first sample while unprimed loads the filter.
        if (!lvl_primed) begin
            for (int i = 0; i < AXES; i++) begin
                lvl_filt[i]     = t_sample'(raw[i]);
                lvl_last_raw[i] = t_sample'(raw[i]);
            end
            lvl_primed     = 1'b1;
            lvl_steady_run = '0;
            return pack_level(LS_HOLD, 0, CAL_OK);
        end

        // Filter step per axis, tracking the largest filtered and raw change.
        for (int i = 0; i < AXES; i++) begin
            old_f       = lvl_filt[i];
            lvl_filt[i] = t_sample'(old_f + ((raw[i] - old_f) >>> FILTER_SHIFT));
            step        = magnitude(longint'(lvl_filt[i]) - old_f);
            if (step > f_big)
                f_big = step;
            step = magnitude(raw[i] - longint'(lvl_last_raw[i]));
            if (step > r_big)
                r_big = step;
            lvl_last_raw[i] = t_sample'(raw[i]);
        end
        if (f_big <= longint'(set_fstep) && r_big <= longint'(set_rstep)) begin
            if (lvl_steady_run < STEADY_COUNT)
                lvl_steady_run++;
        end else begin
            lvl_steady_run = '0;
        end

        // Upright, gravity and steadiness checks, then the tilt.
        fx = lvl_filt[AXIS_X];
        fy = lvl_filt[AXIS_Y];
        fz = lvl_filt[AXIS_Z];
        ax = magnitude(fx);
        ay = magnitude(fy);
        if (ay >= ax) begin
            vert = ay;
            lat  = fx - longint'(lvl_zero[AXIS_X]);
        end else begin
            vert = ax;
            lat  = fy - longint'(lvl_zero[AXIS_Y]);
        end
        grav_sq = fx * fx + fy * fy + fz * fz;
        if (lvl_steady_run < STEADY_COUNT || vert < longint'(set_upright) || vert == 0 ||
            grav_sq < longint'(set_grav_min) * longint'(set_grav_min) ||
            grav_sq > longint'(set_grav_max) * longint'(set_grav_max)) begin
            lvl_level_run = '0;
            return pack_level(LS_HOLD, 0, CAL_OK);
        end
        tilt = lat * PERMILLE / vert;
        if (magnitude(tilt) > longint'(set_tilt_lim)) begin
            lvl_level_run = '0;
            return pack_level(LS_ADJUST, tilt, CAL_OK);
        end
        if (lvl_level_run < LEVEL_COUNT)
            lvl_level_run++;
        return pack_level((lvl_level_run >= LEVEL_COUNT) ? LS_READY : LS_HOLD, tilt, CAL_OK);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("accel_level_assist_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Helpers for the stimulus
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < REPORT_LINES)
            $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Any axis value, with the extremes drawn often.
    function automatic t_sample wild_axis();
        case ($urandom_range(0, 5))
            0:       return t_sample'(-8192);
            1:       return t_sample'(8191);
            2:       return t_sample'(0);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Offers one item, waits for it to be taken and records its expected result.
    task automatic offer_item(input logic [1:0] cmd, input t_sample sx, input t_sample sy,
                              input t_sample sz, input bit typed = 1'b0,
                              input t_level_out want = '0);
        int         gap;
        t_level_out predicted;
        if ($urandom_range(0, 39) == 0)
            calm_src = !calm_src;
        gap = calm_src ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.command <= cmd;
        sample_ch.accel_x <= sx;
        sample_ch.accel_y <= sy;
        sample_ch.accel_z <= sz;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        predicted = level_outcome(cmd, sx, sy, sz);
        awaited_levels.push_back(typed ? want : predicted);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Writes one register; valid stays high across a run of writes.
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_PRESENT:     set_present  = val[0];
            CFG_FSTEP_LIM:   set_fstep    = val[LIMIT_W-1:0];
            CFG_RSTEP_LIM:   set_rstep    = val[LIMIT_W-1:0];
            CFG_UPRIGHT_MIN: set_upright  = val[UPRIGHT_W-1:0];
            CFG_GRAV_MIN:    set_grav_min = val[LIMIT_W-1:0];
            CFG_GRAV_MAX:    set_grav_max = val[LIMIT_W-1:0];
            CFG_TILT_LIM:    set_tilt_lim = val[TILT_LIM_W-1:0];
            CFG_ERR_LIM:     set_err_lim  = val[ERR_W-1:0];
            default: ;
        endcase
        if (last)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input t_setting s);
        cfg_write(CFG_PRESENT,     CFG_DATA_W'(s.present),  1'b0);
        cfg_write(CFG_FSTEP_LIM,   CFG_DATA_W'(s.fstep),    1'b0);
        cfg_write(CFG_RSTEP_LIM,   CFG_DATA_W'(s.rstep),    1'b0);
        cfg_write(CFG_UPRIGHT_MIN, CFG_DATA_W'(s.upright),  1'b0);
        cfg_write(CFG_GRAV_MIN,    CFG_DATA_W'(s.grav_min), 1'b0);
        cfg_write(CFG_GRAV_MAX,    CFG_DATA_W'(s.grav_max), 1'b0);
        cfg_write(CFG_TILT_LIM,    CFG_DATA_W'(s.tilt_lim), 1'b0);
        cfg_write(CFG_ERR_LIM,     CFG_DATA_W'(s.err_lim),  1'b1);
    endtask

    // Stops offering and waits until every result item is back and the block is idle.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (awaited_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A run of samples around one gravity direction, with an occasional calibrate.
    task automatic level_burst();
        bit      x_vertical;
        int      base_v, base_l, base_z, amp, len;
        t_sample sx, sy;
        x_vertical = ($urandom_range(0, 3) == 0);
        base_v     = $urandom_range(500, 1400) * ($urandom_range(0, 1) ? 1 : -1);
        base_l     = ($urandom_range(0, 4) == 0) ? jitter(700) : jitter(90);
        base_z     = jitter(300);
        case ($urandom_range(0, 4))
            0:       amp = 0;
            1:       amp = 2;
            2:       amp = 6;
            3:       amp = 15;
            default: amp = 40;
        endcase
        len = $urandom_range(5, 16);
        repeat (len) begin
            if ($urandom_range(0, 14) == 0)
                offer_item(CMD_CAL, wild_axis(), wild_axis(), wild_axis());
            sx = t_sample'((x_vertical ? base_v : base_l) + jitter(amp));
            sy = t_sample'((x_vertical ? base_l : base_v) + jitter(amp));
            offer_item(CMD_SAMPLE, sx, sy, t_sample'(base_z + jitter(amp)));
        end
    endtask

    // Random stimulus until the item count reaches the given total.
    task automatic random_phase(input int total);
        int pick;
        while (items_sent < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                level_burst();
            end else if (pick < 76) begin
                repeat ($urandom_range(1, 5))
                    offer_item(CMD_FAIL, wild_axis(), wild_axis(), wild_axis());
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3))
                    offer_item(CMD_SAMPLE, wild_axis(), wild_axis(), wild_axis());
            end else if (pick < 96) begin
                offer_item(CMD_CAL, wild_axis(), wild_axis(), wild_axis());
            end else begin
                offer_item(CMD_UNUSED, wild_axis(), wild_axis(), wild_axis());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the comparison
    // ------------------------------------------------------------------------

    initial begin : level_sink
        int         gap;
        t_level_out want;
        level_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm_sink = !calm_sink;
            gap = calm_sink ? 0 : $urandom_range(0, 14);
            if (gap > 0 || sink_hold) begin
                level_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (sink_hold) @(posedge i_clk);
            end
            level_ch.ready <= 1'b1;
            do @(posedge i_clk); while (level_ch.valid !== 1'b1);
            if (awaited_levels.size() == 0) begin
                report_mismatch("unexpected result item, level_status",
                                longint'(level_ch.level_status), -1);
            end else begin
                want = awaited_levels.pop_front();
                if (level_ch.level_status !== want.status)
                    report_mismatch("level_status", longint'(level_ch.level_status),
                                    longint'(want.status));
                if (level_ch.tilt_permille !== want.tilt)
                    report_mismatch("tilt_permille", longint'($signed(level_ch.tilt_permille)),
                                    longint'(want.tilt));
                if (level_ch.capture_allowed !== want.capture)
                    report_mismatch("capture_allowed", longint'(level_ch.capture_allowed),
                                    longint'(want.capture));
                if (level_ch.calibrate_result !== want.cal)
                    report_mismatch("calibrate_result", longint'(level_ch.calibrate_result),
                                    longint'(want.cal));
            end
        end
    end

    // One long receiver stall while items keep coming, so the block backs up.
    initial begin : backpressure
        repeat (HOLD_START) @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        t_drive_row row;
        t_setting   mix;

        i_rst_n           <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.command <= CMD_SAMPLE;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_PRESENT;
        cfg_ch.data       <= '0;
        level_model_reset();

        // Defaults after reset: early failures, priming, a level run and calibration.
        directed_rows = '{
            '{CMD_CAL,    0,     0,     0,     1'b1, LS_HOLD,    0, CAL_NOT_READY},
            '{CMD_UNUSED, 0,     0,     0,     1'b1, LS_HOLD,    0, CAL_OK},
            '{CMD_FAIL,   0,     0,     0,     1'b1, LS_HOLD,    0, CAL_OK},
            '{CMD_FAIL,   0,     0,     0,     1'b1, LS_HOLD,    0, CAL_OK},
            '{CMD_FAIL,   0,     0,     0,     1'b1, LS_UNAVAIL, 0, CAL_OK},
            '{CMD_FAIL,   0,     0,     0,     1'b1, LS_UNAVAIL, 0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b1, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_CAL,    0,     0,     0,     1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 40,    1020,  -30,   1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 8191,  -8192, 8191,  1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, -8192, 8191,  -8192, 1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, -1,    -1,    -1,    1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_FAIL,   0,     0,     0,     1'b1, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 0,     0,     0,     1'b1, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 0,     0,     0,     1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 0,     0,     0,     1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 0,     0,     0,     1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_SAMPLE, 0,     0,     0,     1'b0, LS_HOLD,    0, CAL_OK},
            '{CMD_CAL,    0,     0,     0,     1'b0, LS_HOLD,    0, CAL_OK}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; typed rows carry their own result, the rest use the model.
        for (int i = 0; i < DIRECTED_N; i++) begin
            row = directed_rows[i];
            offer_item(row.cmd, row.ax, row.ay, row.az, row.typed,
                       pack_level(row.status, row.tilt, row.cal));
        end
        random_phase(200);
        drain_results();

        // Widest limits: almost every steady sample counts as level or adjust.
        apply_settings('{1'b1, 14'd16383, 14'd16383, 13'd256, 14'd0, 14'd16383,
                         10'd1000, 4'd15});
        random_phase(390);
        drain_results();

        // Sensor absent.
        apply_settings('{1'b0, DEF_FSTEP_LIM, DEF_RSTEP_LIM, DEF_UPRIGHT_MIN, DEF_GRAV_MIN,
                         DEF_GRAV_MAX, DEF_TILT_LIM, DEF_ERR_LIM});
        random_phase(560);
        drain_results();

        // Tightest limits, with a gravity window that admits nothing.
        apply_settings('{1'b1, 14'd0, 14'd0, 13'd8191, 14'd16383, 14'd0, 10'd0, 4'd1});
        random_phase(750);
        drain_results();

        // Moderate hand-picked limits.
        apply_settings('{1'b1, 14'd40, 14'd120, 13'd450, 14'd650, 14'd1500, 10'd200, 4'd2});
        random_phase(950);
        drain_results();

        // Random limits around typical use.
        mix.present  = 1'b1;
        mix.fstep    = LIMIT_W'($urandom_range(5, 200));
        mix.rstep    = LIMIT_W'($urandom_range(20, 400));
        mix.upright  = UPRIGHT_W'($urandom_range(256, 1000));
        mix.grav_min = LIMIT_W'($urandom_range(300, 900));
        mix.grav_max = LIMIT_W'($urandom_range(1100, 2000));
        mix.tilt_lim = TILT_LIM_W'($urandom_range(0, 1000));
        mix.err_lim  = ERR_W'($urandom_range(1, 15));
        apply_settings(mix);
        random_phase(1150);
        drain_results();

        // Back to the reset values.
        apply_settings('{DEF_PRESENT, DEF_FSTEP_LIM, DEF_RSTEP_LIM, DEF_UPRIGHT_MIN,
                         DEF_GRAV_MIN, DEF_GRAV_MAX, DEF_TILT_LIM, DEF_ERR_LIM});
        random_phase(1350);
        drain_results();

        if (mismatch_count == 0) begin
            $display("accel_level_assist_core_tb: PASS");
        end else begin
            $display("accel_level_assist_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ala_pkg.sv
hw/rtl/ala_intf.sv
hw/rtl/ala_axis_lane.sv
hw/rtl/ala_merge.sv
hw/rtl/ala_divider.sv
hw/rtl/accel_level_assist_core.sv
sim/accel_level_assist_core_tb.sv
